/* design/lcrc_pkg.sv */
package lcrc_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  LINE_END  = 8'h0a;
    localparam logic [2:0]  MIN_LINE  = 3'd5;
    localparam logic [2:0]  CRC_START = 3'd4;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NO_NEWLINE = 3'd1,
        STAT_TOO_SHORT  = 3'd2,
        STAT_BAD_HEX    = 3'd3,
        STAT_MISMATCH   = 3'd4
    } status_t;

    typedef logic [3:0][7:0] tail_t;

    typedef struct packed {
        logic        ok;
        logic [3:0]  nib;
    } hex_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] value;
    } parse_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic hex_t hex_val(input logic [7:0] ch);
        hex_t h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (ch >= "0" && ch <= "9")
            h.nib = 4'(ch - "0");
        else if (ch >= "a" && ch <= "f")
            h.nib = 4'(ch - "a" + 8'd10);
        else if (ch >= "A" && ch <= "F")
            h.nib = 4'(ch - "A" + 8'd10);
        else
            h.ok = 1'b0;
        return h;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return ch == 8'h20 || ch == 8'h09 || ch == 8'h0b || ch == 8'h0c || ch == 8'h0d;
    endfunction

    // Element 0 of the tail is the oldest character, i.e. the first one of the trailer.
    function automatic parse_t parse_tail(input tail_t t);
        parse_t      p;
        logic [2:0]  pos;
        logic        leading;
        logic        neg;
        logic [1:0]  idx1;
        logic [1:0]  idx2;
        hex_t        h;
        p.ok    = 1'b1;
        p.value = 16'd0;
        pos     = 3'd0;
        leading = 1'b1;
        neg     = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (leading && is_blank(t[k]))
                pos = 3'(k + 1);
            else
                leading = 1'b0;
        end
        if (pos < 3'd4 && (t[pos[1:0]] == "+" || t[pos[1:0]] == "-"))
        begin
            neg = (t[pos[1:0]] == "-");
            pos = pos + 3'd1;
        end
        idx1 = pos[1:0] + 2'd1;
        idx2 = pos[1:0] + 2'd2;
        if (pos <= 3'd1 && t[pos[1:0]] == "0" && (t[idx1] == "x" || t[idx1] == "X")
            && hex_val(t[idx2]).ok)
            pos = pos + 3'd2;
        for (int k = 0; k < 4; k++)
        begin
            h = hex_val(t[k]);
            if (3'(k) >= pos)
            begin
                if (!h.ok)
                    p.ok = 1'b0;
                p.value = {p.value[11:0], h.nib};
            end
        end
        // At least one digit must remain after blanks, sign and prefix.
        if (pos >= 3'd4)
            p.ok = 1'b0;
        if (neg)
            p.value = 16'd0 - p.value;
        if (!p.ok)
            p.value = 16'd0;
        return p;
    endfunction

endpackage

/* design/lcrc_if.sv */
interface lcrc_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_first;

    modport source (output valid, output data_byte, output frame_first, input ready);
    modport sink   (input valid, input data_byte, input frame_first, output ready);
endinterface

interface lcrc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;

    modport source (output valid, output status, output computed_crc, output received_crc,
                    input ready);
    modport sink   (input valid, input status, input computed_crc, input received_crc,
                    output ready);
endinterface

/* design/line_crc16_hex_trailer_check.sv */
// Channel   Direction  Payload                                     Handshake
// line      in         data_byte[7:0], frame_first                 valid/ready
// result    out        status[2:0], computed_crc[15:0],            valid/ready
//                      received_crc[15:0]
//
// One byte is taken every cycle, but for the stall below; the CRC step and the
// trailer parse are one level of logic ahead of the line state and result registers.
// A result is valid in the cycle after the line's closing newline or zero byte is taken.
// The result register holds while result.ready is low; a new byte is still
// taken then unless it would produce a result into the occupied register.
// rst_n clears the frame state and drops the result valid asynchronously.
module line_crc16_hex_trailer_check
    import lcrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lcrc_line_if.sink     line,
    lcrc_result_if.source result
);

    logic [15:0] crc_reg, crc_next;
    tail_t       tail_reg, tail_next;
    logic [2:0]  count_reg, count_next;
    logic        open_reg, open_next;

    logic        res_valid_reg, res_valid_next;
    status_t     status_reg, status_next;
    logic [15:0] ccrc_reg, ccrc_next;
    logic [15:0] rcrc_reg, rcrc_next;

    logic        accept;
    logic        eff_open;
    logic        ends_line;
    logic        has_result;
    logic [15:0] eff_crc;
    tail_t       eff_tail;
    logic [2:0]  eff_count;
    parse_t      parsed;

    assign eff_open  = line.frame_first | open_reg;
    assign eff_crc   = line.frame_first ? 16'd0 : crc_reg;
    assign eff_tail  = line.frame_first ? tail_t'(0) : tail_reg;
    assign eff_count = line.frame_first ? 3'd0 : count_reg;
    assign ends_line = (line.data_byte == 8'h00) || (line.data_byte == LINE_END);
    assign has_result = eff_open && ends_line;

    // A byte that closes a line needs room in the result register.
    assign line.ready = !res_valid_reg || result.ready || !has_result;
    assign accept     = line.valid && line.ready;
    assign parsed     = parse_tail(eff_tail);

    always_comb
    begin
        crc_next       = crc_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        open_next      = open_reg;
        res_valid_next = res_valid_reg && !result.ready;
        status_next    = status_reg;
        ccrc_next      = ccrc_reg;
        rcrc_next      = rcrc_reg;
        if (accept && eff_open)
        begin
            crc_next   = eff_crc;
            tail_next  = eff_tail;
            count_next = eff_count;
            open_next  = 1'b1;
            if (ends_line)
            begin
                open_next      = 1'b0;
                res_valid_next = 1'b1;
                ccrc_next      = 16'd0;
                rcrc_next      = 16'd0;
                if (line.data_byte == 8'h00)
                    status_next = STAT_NO_NEWLINE;
                else if (eff_count < MIN_LINE)
                    status_next = STAT_TOO_SHORT;
                else
                begin
                    ccrc_next = eff_crc;
                    rcrc_next = parsed.value;
                    if (!parsed.ok)
                        status_next = STAT_BAD_HEX;
                    else if (parsed.value != eff_crc)
                        status_next = STAT_MISMATCH;
                    else
                        status_next = STAT_OK;
                end
            end
            else
            begin
                // The byte leaving the delay line is the next body byte.
                if (eff_count >= CRC_START)
                    crc_next = crc_update(eff_crc, eff_tail[0]);
                tail_next = {line.data_byte, eff_tail[3:1]};
                if (eff_count < MIN_LINE)
                    count_next = eff_count + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= 16'd0;
            tail_reg      <= tail_t'(0);
            count_reg     <= 3'd0;
            open_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            open_reg      <= open_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ccrc_reg   <= ccrc_next;
        rcrc_reg   <= rcrc_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.status       = status_reg;
    assign result.computed_crc = ccrc_reg;
    assign result.received_crc = rcrc_reg;

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MIN_LINE)
        else $error("byte count passed its saturation value");

    a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && status_reg == STAT_OK |-> ccrc_reg == rcrc_reg)
        else $error("ok reported with differing CRC values");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (status_reg == STAT_TOO_SHORT || status_reg == STAT_NO_NEWLINE)
        |-> ccrc_reg == 16'd0 && rcrc_reg == 16'd0)
        else $error("early end carries nonzero CRC fields");

    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        accept && has_result |=> !open_reg && res_valid_reg)
        else $error("line end did not close the frame and post a result");

endmodule
